// ===== design/gtp_pkg.sv =====
// shared constants and types for the gray to pseudocolour pipeline
// no dependencies; used by every module of the block
`default_nettype none

package gtp_pkg;

  // fraction bits of the fixed-point datapath
  localparam int FRAC_BITS_DEF = 16;

  // field widths
  localparam int GRAY_W = 8;
  localparam int HUE_W  = 9;
  localparam int SAT_W  = 17;
  localparam int BYTE_W = 8;

  // arithmetic constants
  localparam int GRAY_MAX  = 255;
  localparam int HUE_MOD   = 360;
  localparam int SAT_FULL  = 65536;
  localparam int SAT_FRAC  = 16;

  // register file
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_HUE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT = 1'b1;
  localparam int HUE_RESET = 100;
  localparam int SAT_RESET = 32768;

  // pipeline depth: 2 front, 2 temp, 4 per channel lane
  localparam int STAGES = 8;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
  } cfg_t;

endpackage

`default_nettype wire

// ===== design/gtp_front.sv =====
// front stages: lightness, hue and saturation in fixed point
// depends on gtp_pkg
`default_nettype none

module gtp_front #(
  parameter int FRAC_BITS = gtp_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic [1:0]                  en,
  input  logic [gtp_pkg::GRAY_W-1:0]  gray,
  input  gtp_pkg::cfg_t               cfg,
  output logic [FRAC_BITS:0]          l,
  output logic [FRAC_BITS-1:0]        h,
  output logic [FRAC_BITS:0]          s
);

  localparam int F  = FRAC_BITS;
  localparam int GW = gtp_pkg::GRAY_W;
  localparam int HW = gtp_pkg::HUE_W;
  localparam int SW = gtp_pkg::SAT_W;

  // truncated reciprocals; the estimate is the quotient or one below it
  localparam logic [F:0] RECIP_L = (F+1)'((64'd1 << (F + GW)) / gtp_pkg::GRAY_MAX);
  localparam logic [F:0] RECIP_H = (F+1)'((64'd1 << (F + HW)) / gtp_pkg::HUE_MOD);

  logic [HW-1:0]   hue_w;
  logic [SW-1:0]   sat_c;
  logic [GW+F:0]   prod_l;
  logic [HW+F:0]   prod_h;
  logic [SW+F-1:0] s_wide;
  logic [GW+F:0]   rem_l;
  logic [HW+F:0]   rem_h;
  logic [F:0]      h_sum;

  logic [GW-1:0]   gray_q;
  logic [HW-1:0]   hue_q;
  logic [F:0]      lq0;
  logic [F:0]      hq0;
  logic [F:0]      s1;

  always_comb begin
    hue_w  = (cfg.hue >= HW'(gtp_pkg::HUE_MOD)) ? cfg.hue - HW'(gtp_pkg::HUE_MOD) : cfg.hue;
    sat_c  = (cfg.sat > SW'(gtp_pkg::SAT_FULL)) ? SW'(gtp_pkg::SAT_FULL) : cfg.sat;
    prod_l = (GW+F+1)'(gray) * (GW+F+1)'(RECIP_L);
    prod_h = (HW+F+1)'(hue_w) * (HW+F+1)'(RECIP_H);
    s_wide = {sat_c, {F{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      gray_q <= gray;
      hue_q  <= hue_w;
      lq0    <= prod_l[GW+F:GW];
      hq0    <= prod_h[HW+F:HW];
      s1     <= s_wide[gtp_pkg::SAT_FRAC+F:gtp_pkg::SAT_FRAC];
    end
  end

  // remainder check fixes the estimate up by one where needed
  always_comb begin
    rem_l = (GW+F+1)'({gray_q, {F{1'b0}}})
          - (GW+F+1)'(lq0) * (GW+F+1)'(gtp_pkg::GRAY_MAX);
    rem_h = (HW+F+1)'({hue_q, {F{1'b0}}})
          - (HW+F+1)'(hq0) * (HW+F+1)'(gtp_pkg::HUE_MOD);
    h_sum = hq0 + (F+1)'(rem_h >= (HW+F+1)'(gtp_pkg::HUE_MOD));
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      l <= lq0 + (F+1)'(rem_l >= (GW+F+1)'(gtp_pkg::GRAY_MAX));
      h <= h_sum[F-1:0];
      s <= s1;
    end
  end

endmodule

`default_nettype wire

// ===== design/gtp_temp.sv =====
// temp1/temp2 stages and the three channel hues
// depends on gtp_pkg
`default_nettype none

module gtp_temp #(
  parameter int FRAC_BITS = gtp_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic [1:0]             en,
  input  logic [FRAC_BITS:0]     l,
  input  logic [FRAC_BITS-1:0]   h,
  input  logic [FRAC_BITS:0]     s,
  output logic [FRAC_BITS:0]     t1,
  output logic [FRAC_BITS:0]     t2,
  output logic [FRAC_BITS:0]     d,
  output logic [2:0][FRAC_BITS:0] hue_ch
);

  localparam int F = FRAC_BITS;
  localparam logic [F:0] ONE   = (F+1)'(64'd1 << F);
  localparam logic [F:0] HALF  = (F+1)'(64'd1 << (F - 1));
  localparam logic [F:0] THIRD = (F+1)'((64'd1 << F) / 3);

  logic [2*F+1:0] p;
  logic [F:0]     pf;
  logic [F:0]     l3;
  logic [F:0]     s3;
  logic [F:0]     h3;
  logic           lo;

  logic [F:0]     e;
  logic [F:0]     c_up;
  logic [F:0]     c_dn;

  always_comb begin
    p = (2*F+2)'(l) * (2*F+2)'(s);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pf <= p[2*F:F];
      l3 <= l;
      s3 <= s;
      h3 <= (F+1)'(h);
      lo <= (l < HALF);
    end
  end

  // temp1 = l + e, temp2 = l - e, so their difference is 2e
  always_comb begin
    e    = lo ? pf : s3 - pf;
    c_up = h3 + THIRD;
    if (c_up > ONE) begin
      c_up = c_up - ONE;
    end
    c_dn = (h3 < THIRD) ? h3 + (ONE - THIRD) : h3 - THIRD;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      t1        <= l3 + e;
      t2        <= l3 - e;
      d         <= {e[F-1:0], 1'b0};
      hue_ch[0] <= c_up;
      hue_ch[1] <= h3;
      hue_ch[2] <= c_dn;
    end
  end

endmodule

`default_nettype wire

// ===== design/gtp_lane.sv =====
// one colour channel: segment select, ramp multiply, add, scale to a byte
// depends on gtp_pkg
`default_nettype none

module gtp_lane #(
  parameter int FRAC_BITS = gtp_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic [3:0]                  en,
  input  logic [FRAC_BITS:0]          c,
  input  logic [FRAC_BITS:0]          t1,
  input  logic [FRAC_BITS:0]          t2,
  input  logic [FRAC_BITS:0]          d,
  output logic [gtp_pkg::BYTE_W-1:0]  level
);

  localparam int F  = FRAC_BITS;
  localparam int BW = gtp_pkg::BYTE_W;
  localparam logic [F+3:0] ONE_X = (F+4)'(64'd1 << F);
  localparam logic [F+3:0] TWO_X = (F+4)'(64'd2 << F);
  localparam logic [F:0]   TWO3  = (F+1)'((64'd2 << F) / 3);

  logic [F+3:0]  c6;
  logic [F+3:0]  c2;
  logic [F+3:0]  c3;
  logic [F+3:0]  k6;
  logic [F:0]    m_n;
  logic          add_n;
  logic [F:0]    base_n;

  logic [F:0]    m;
  logic          add_a;
  logic [F:0]    base_a;
  logic [F:0]    d_a;

  logic [2*F+1:0] prod;
  logic [F:0]     prod_f;
  logic           add_b;
  logic [F:0]     base_b;

  logic [F+1:0]   v;
  logic [F+9:0]   y;

  // piecewise-linear channel curve
  always_comb begin
    c6     = (F+4)'(c) * (F+4)'(6);
    c2     = (F+4)'(c) << 1;
    c3     = (F+4)'(c) * (F+4)'(3);
    k6     = (F+4)'(TWO3 - c) * (F+4)'(6);
    m_n    = '0;
    add_n  = 1'b0;
    base_n = t2;
    if (c6 < ONE_X) begin
      m_n   = c6[F:0];
      add_n = 1'b1;
    end else if (c2 < ONE_X) begin
      base_n = t1;
    end else if (c3 < TWO_X) begin
      m_n   = k6[F:0];
      add_n = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      m      <= m_n;
      add_a  <= add_n;
      base_a <= base_n;
      d_a    <= d;
    end
  end

  always_comb begin
    prod = (2*F+2)'(d_a) * (2*F+2)'(m);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      prod_f <= prod[2*F:F];
      add_b  <= add_a;
      base_b <= base_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      v <= (F+2)'(base_b) + (add_b ? (F+2)'(prod_f) : (F+2)'(0));
    end
  end

  always_comb begin
    y = (F+10)'(v) * (F+10)'(gtp_pkg::GRAY_MAX);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      level <= (y[F+9:F] > 10'(gtp_pkg::GRAY_MAX)) ? BW'(gtp_pkg::GRAY_MAX) : y[F+BW-1:F];
    end
  end

endmodule

`default_nettype wire

// ===== design/gray_to_pseudocolor_rgb.sv =====
// top level of the gray to pseudocolour block: config registers, pipeline control
// depends on gtp_pkg, gtp_front, gtp_temp, gtp_lane
`default_nettype none

// Each gray beat is taken as the lightness of an HSL colour whose hue and
// saturation sit in two config registers (index 0: hue in degrees, wrapped
// at 360; index 1: saturation in 1/65536 units, held at 1.0), and leaves as
// an 8-bit red/green/blue beat. The datapath is an eight-stage pipeline
// that takes one beat per clock whenever in_stall is low: two stages
// turn gray, hue and saturation into fixed point (reciprocal estimate, then
// a remainder correction), two form temp1/temp2 and the three channel hues,
// and four per channel pick the curve segment, multiply the ramp, add and
// scale to a byte. Each stage carries a valid bit; a stage loads whenever it
// is empty or the stage after it moves, so bubbles close up and in_stall
// only rises once every stage holds a beat and out_stall is high. The last
// stage is the output register. Config writes are only legal while the
// pipeline is empty.

module gray_to_pseudocolor_rgb #(
  parameter int FRAC_BITS = gtp_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // config write port
  input  logic                           cfg_we,
  input  logic [gtp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gtp_pkg::SAT_W-1:0]      cfg_data,
  // input beat
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [gtp_pkg::GRAY_W-1:0]     gray,
  // output beat
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [gtp_pkg::BYTE_W-1:0]     red,
  output logic [gtp_pkg::BYTE_W-1:0]     green,
  output logic [gtp_pkg::BYTE_W-1:0]     blue
);

  localparam int F = FRAC_BITS;
  localparam int N = gtp_pkg::STAGES;

  gtp_pkg::cfg_t  cfg;
  logic [N-1:0]   vld;
  logic [N-1:0]   en;

  // datapath between modules
  logic [F:0]        l;
  logic [F-1:0]      h;
  logic [F:0]        s;
  logic [F:0]        t1;
  logic [F:0]        t2;
  logic [F:0]        d;
  logic [2:0][F:0]   hue_ch;
  logic [2:0][gtp_pkg::BYTE_W-1:0] level;

  // config registers; an index outside the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hue <= gtp_pkg::HUE_W'(gtp_pkg::HUE_RESET);
      cfg.sat <= gtp_pkg::SAT_W'(gtp_pkg::SAT_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        gtp_pkg::CFG_HUE: begin
          cfg.hue <= cfg_data[gtp_pkg::HUE_W-1:0];
        end
        gtp_pkg::CFG_SAT: begin
          cfg.sat <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // stage load enables, from the output back to the input
  always_comb begin
    en[N-1] = !vld[N-1] || !out_stall;
    for (int i = N - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  // valid bits move with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < N; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld[N-1];

  // stages 0..1
  gtp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk  (clk),
    .en   (en[1:0]),
    .gray (gray),
    .cfg  (cfg),
    .l    (l),
    .h    (h),
    .s    (s)
  );

  // stages 2..3
  gtp_temp #(.FRAC_BITS(FRAC_BITS)) u_temp (
    .clk    (clk),
    .en     (en[3:2]),
    .l      (l),
    .h      (h),
    .s      (s),
    .t1     (t1),
    .t2     (t2),
    .d      (d),
    .hue_ch (hue_ch)
  );

  // stages 4..7, one lane per colour: red, green, blue
  for (genvar g = 0; g < 3; g++) begin : g_lane
    gtp_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk   (clk),
      .en    (en[7:4]),
      .c     (hue_ch[g]),
      .t1    (t1),
      .t2    (t2),
      .d     (d),
      .level (level[g])
    );
  end

  assign red   = level[0];
  assign green = level[1];
  assign blue  = level[2];

endmodule

`default_nettype wire

// ===== design/gtp_props.sv =====
// port-level checks for the gray to pseudocolour block, bound to its top level
// depends on gray_to_pseudocolor_rgb and gtp_pkg
`default_nettype none

module gtp_props (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [gtp_pkg::BYTE_W-1:0]    red,
  input logic [gtp_pkg::BYTE_W-1:0]    green,
  input logic [gtp_pkg::BYTE_W-1:0]    blue
);

  // a held result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output beat dropped while stalled");

  // a held result beat keeps its pixel
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(red) && $stable(green) && $stable(blue))
    else $error("output pixel changed while stalled");

  // back-pressure only comes from a stalled output beat
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || !out_stall) |-> !in_stall)
    else $error("input stalled with output free");

  // reset empties the pipeline, and an idle input cannot fill it
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output beat straight after reset");

  a_in_idle: assert property (@(posedge clk) disable iff (rst)
    !in_valid && !out_valid |=> !in_stall)
    else $error("stall with nothing in flight at the output");

endmodule

bind gray_to_pseudocolor_rgb gtp_props u_gtp_props (.*);

`default_nettype wire
